// ===== design/lfv_pkg.sv =====
// ----------------------------------------------------------------------------
// lfv_pkg
// Shared types, constants and the CRC-32 byte update for the lidar frame
// validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfv_pkg;

  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned TAIL_BYTES   = 12;
  localparam int unsigned MAX_BYTES    = 4096;
  localparam int unsigned MIN_FRAME    = HEADER_BYTES + TAIL_BYTES;

  // The byte counter saturates at MAX_BYTES + 1.
  localparam int unsigned CNT_W  = $clog2(MAX_BYTES + 2);
  localparam int unsigned CFG_W  = 13;
  localparam logic [CFG_W-1:0] CFG_MAX_RESET = 13'd4096;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [7:0] MAGIC_BYTES [4] = '{8'h55, 8'hAA, 8'h05, 8'h0A};
  localparam logic [15:0] TAIL_MARK = 16'h00FF;

  // Queue between front and back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned QPTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_BAD_HDR   = 3'd2,
    ST_BAD_SIZE  = 3'd3,
    ST_BAD_TAIL  = 3'd4,
    ST_BAD_CRC   = 3'd5
  } status_t;

  // What the back end does with one byte.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_MAGIC  = 3'd1,
    OP_KIND   = 3'd2,
    OP_CRC    = 3'd3,
    OP_STORED = 3'd4
  } byte_op_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    byte_op_t   op;
    logic [1:0] lane;
    logic       trunc;
    logic       size_bad;
  } q_entry_t;

  // Reflected CRC-32 over one byte, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/lfv_front.sv =====
// ----------------------------------------------------------------------------
// lfv_front
// Accepts frame bytes, tracks the byte position and declared length, and
// tags each byte with the operation the back end performs on it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfv_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 in_data_byte,
  input  wire logic                       in_last_byte,
  input  wire logic [lfv_pkg::CFG_W-1:0]  max_frame_size,
  input  wire logic                       q_full,
  output logic                            q_push,
  output lfv_pkg::q_entry_t               q_entry
);

  logic [lfv_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [31:0]               dl_r, dl_nxt, dl_upd;
  logic [32:0]               pos_w, dl_w, diff_w;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    dl_upd          = dl_r;
    q_entry.data    = in_data_byte;
    q_entry.last    = in_last_byte;
    q_entry.op      = lfv_pkg::OP_NONE;
    q_entry.lane    = cnt_r[1:0];
    pos_w           = 33'(cnt_r) + 33'(lfv_pkg::TAIL_BYTES);
    dl_w            = {1'b0, dl_r};
    diff_w          = pos_w - dl_w;

    if (cnt_r < lfv_pkg::CNT_W'(4)) begin
      q_entry.op = lfv_pkg::OP_MAGIC;
    end else if (cnt_r < lfv_pkg::CNT_W'(8)) begin
      q_entry.op = lfv_pkg::OP_KIND;
    end else if (cnt_r < lfv_pkg::CNT_W'(lfv_pkg::HEADER_BYTES)) begin
      dl_upd[{cnt_r[1:0], 3'b000} +: 8] = in_data_byte;
    end else if (cnt_r <= lfv_pkg::CNT_W'(lfv_pkg::MAX_BYTES)) begin
      if (pos_w < dl_w) begin
        q_entry.op = lfv_pkg::OP_CRC;
      end else if (diff_w < 33'd4) begin
        q_entry.op   = lfv_pkg::OP_STORED;
        q_entry.lane = diff_w[1:0];
      end
    end

    cnt_inc = (cnt_r <= lfv_pkg::CNT_W'(lfv_pkg::MAX_BYTES)) ?
              cnt_r + lfv_pkg::CNT_W'(1) : cnt_r;

    q_entry.trunc    = cnt_inc < lfv_pkg::CNT_W'(lfv_pkg::MIN_FRAME);
    q_entry.size_bad = (cnt_inc > lfv_pkg::CNT_W'(lfv_pkg::MAX_BYTES)) ||
                       (dl_upd != 32'(cnt_inc)) ||
                       (dl_upd > 32'(max_frame_size));

    cnt_nxt = cnt_r;
    dl_nxt  = dl_r;
    if (q_push) begin
      if (in_last_byte) begin
        cnt_nxt = '0;
        dl_nxt  = '0;
      end else begin
        cnt_nxt = cnt_inc;
        dl_nxt  = dl_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      dl_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      dl_r  <= dl_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/lfv_queue.sv =====
// ----------------------------------------------------------------------------
// lfv_queue
// Short first-in first-out queue of tagged bytes between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfv_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire lfv_pkg::q_entry_t  push_entry,
  output logic                    full,
  input  wire logic               pop,
  output lfv_pkg::q_entry_t       head_entry,
  output logic                    head_valid
);

  lfv_pkg::q_entry_t                mem_r [lfv_pkg::Q_DEPTH];
  logic [lfv_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [lfv_pkg::QCNT_W-1:0]       cnt_r, cnt_nxt;

  localparam logic [lfv_pkg::QPTR_W-1:0] LAST_PTR =
    lfv_pkg::QPTR_W'(lfv_pkg::Q_DEPTH - 1);

  assign full       = (cnt_r == lfv_pkg::QCNT_W'(lfv_pkg::Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + lfv_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - lfv_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== design/lfv_back.sv =====
// ----------------------------------------------------------------------------
// lfv_back
// Executes tagged bytes: magic check, packet type capture, CRC update and
// stored CRC capture, then resolves the status on the last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfv_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               head_valid,
  input  wire lfv_pkg::q_entry_t  head_entry,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_status,
  output logic [31:0]             out_packet_kind
);

  logic [31:0]      crc_r, crc_nxt, crc_upd;
  logic             hdr_r, hdr_nxt, hdr_upd;
  logic [31:0]      kind_r, kind_nxt, kind_upd;
  logic [31:0]      stored_r, stored_nxt, stored_upd;
  logic [15:0]      recent_r, recent_nxt, recent_upd;
  logic             ov_r, ov_nxt;
  lfv_pkg::status_t st_r, st_nxt, st_calc;
  logic [31:0]      pk_r, pk_nxt;

  // A non-final byte never waits on the output register.
  assign pop = head_valid && (!head_entry.last || !ov_r || out_ready);

  always_comb begin
    crc_upd    = crc_r;
    hdr_upd    = hdr_r;
    kind_upd   = kind_r;
    stored_upd = stored_r;
    recent_upd = {recent_r[7:0], head_entry.data};

    unique case (head_entry.op)
      lfv_pkg::OP_MAGIC: begin
        if (head_entry.data != lfv_pkg::MAGIC_BYTES[head_entry.lane]) begin
          hdr_upd = 1'b0;
        end
      end
      lfv_pkg::OP_KIND:   kind_upd[{head_entry.lane, 3'b000} +: 8] = head_entry.data;
      lfv_pkg::OP_CRC:    crc_upd = lfv_pkg::crc_byte(crc_r, head_entry.data);
      lfv_pkg::OP_STORED: stored_upd[{head_entry.lane, 3'b000} +: 8] = head_entry.data;
      default: begin
      end
    endcase

    priority if (head_entry.trunc) begin
      st_calc = lfv_pkg::ST_TRUNCATED;
    end else if (!hdr_upd) begin
      st_calc = lfv_pkg::ST_BAD_HDR;
    end else if (head_entry.size_bad) begin
      st_calc = lfv_pkg::ST_BAD_SIZE;
    end else if (recent_upd != lfv_pkg::TAIL_MARK) begin
      st_calc = lfv_pkg::ST_BAD_TAIL;
    end else if ((crc_upd ^ lfv_pkg::CRC_INIT) != stored_upd) begin
      st_calc = lfv_pkg::ST_BAD_CRC;
    end else begin
      st_calc = lfv_pkg::ST_OK;
    end

    crc_nxt    = crc_r;
    hdr_nxt    = hdr_r;
    kind_nxt   = kind_r;
    stored_nxt = stored_r;
    recent_nxt = recent_r;
    ov_nxt     = ov_r && !out_ready;
    st_nxt     = st_r;
    pk_nxt     = pk_r;

    if (pop) begin
      if (head_entry.last) begin
        crc_nxt    = lfv_pkg::CRC_INIT;
        hdr_nxt    = 1'b1;
        kind_nxt   = '0;
        stored_nxt = '0;
        recent_nxt = '0;
        ov_nxt     = 1'b1;
        st_nxt     = st_calc;
        pk_nxt     = kind_upd;
      end else begin
        crc_nxt    = crc_upd;
        hdr_nxt    = hdr_upd;
        kind_nxt   = kind_upd;
        stored_nxt = stored_upd;
        recent_nxt = recent_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= lfv_pkg::CRC_INIT;
      hdr_r    <= 1'b1;
      kind_r   <= '0;
      stored_r <= '0;
      recent_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      crc_r    <= crc_nxt;
      hdr_r    <= hdr_nxt;
      kind_r   <= kind_nxt;
      stored_r <= stored_nxt;
      recent_r <= recent_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    pk_r <= pk_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = st_r;
  assign out_packet_kind = pk_r;

endmodule

`default_nettype wire

// ===== design/lidar_frame_validator_core.sv =====
// ----------------------------------------------------------------------------
// lidar_frame_validator_core
// Streaming checker for framed lidar packets: magic header, declared
// length, 00 FF tail and CRC-32 over the payload, one status per frame.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Signals                              Transaction
//   in_       input      in_data_byte[7:0], in_last_byte      one frame byte
//   out_      output     out_status[2:0], out_packet_kind     one frame result
//   cfg_      input      cfg_max_frame_size[12:0]             limit write
//
// One byte is taken every cycle while the queue is not full; the CRC is
// updated a whole byte per cycle while bytes are popped. For a result,
// the last byte is written into the queue at its transaction, and the back
// end registers the status as it pops the byte.
// A stalled result holds only the next final byte in the back end; the
// two-entry queue keeps the front taking bytes until it fills.
// Reset (rst_n low, synchronous) clears the frame state and sets the
// size limit to 4096 bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lidar_frame_validator_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 in_data_byte,
  input  wire logic                       in_last_byte,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [2:0]                      out_status,
  output logic [31:0]                     out_packet_kind,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [lfv_pkg::CFG_W-1:0]  cfg_max_frame_size
);

  // Size limit register. Writes must be issued only while no frame is in
  // flight; the block does not enforce this. Every write is accepted.
  logic [lfv_pkg::CFG_W-1:0] max_size_r, max_size_nxt;

  assign cfg_ready    = 1'b1;
  assign max_size_nxt = (cfg_valid && cfg_ready) ? cfg_max_frame_size : max_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= lfv_pkg::CFG_MAX_RESET;
    end else begin
      max_size_r <= max_size_nxt;
    end
  end

  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_head_valid;
  lfv_pkg::q_entry_t q_push_entry;
  lfv_pkg::q_entry_t q_head_entry;

  // Front: position tracking, declared length capture, size verdict.
  lfv_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .max_frame_size (max_size_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_push_entry)
  );

  lfv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_entry (q_head_entry),
    .head_valid (q_head_valid)
  );

  // Back: header, CRC and tail checks, result register.
  lfv_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head_entry      (q_head_entry),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_packet_kind (out_packet_kind)
  );

endmodule

`default_nettype wire

// ===== design/lfv_checker.sv =====
// ----------------------------------------------------------------------------
// lfv_checker
// Port-level checks for the lidar frame validator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfv_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       in_last_byte,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [2:0]                 out_status,
  input wire logic [31:0]                out_packet_kind
);

  // A result waiting on the sink holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_packet_kind))
    else $error("result changed while stalled");

  // Only defined status codes are reported.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= lfv_pkg::ST_BAD_CRC)
    else $error("undefined status code");

  // No result is presented right out of reset.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) == 1'b0 |-> !out_valid)
    else $error("result valid after reset");

  // A new result always follows the transaction of a final byte.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |->
      $past(in_valid && in_ready && in_last_byte, 2) ||
      $past(in_valid && in_ready && in_last_byte, 3))
    else $error("result without a final byte");

endmodule

bind lidar_frame_validator_core lfv_checker u_lfv_checker (.*);

`default_nettype wire

// ===== tb/lfv_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// lfv_tb_pkg
// CRC-32 helper shared by the frame builder and the result predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfv_tb_pkg;

  // Reflected CRC-32, one byte, least significant bit first.
  function automatic logic [31:0] crc32_shift_byte(input logic [31:0] acc,
                                                   input logic [7:0]  b);
    logic [31:0] r;
    r = acc ^ {24'h0, b};
    repeat (8) r = {1'b0, r[31:1]} ^ (r[0] ? lfv_pkg::CRC_POLY : 32'h0);
    return r;
  endfunction

endpackage

// ===== tb/lfv_frame_checker.sv =====
// ----------------------------------------------------------------------------
// lfv_frame_checker
// Watches the byte, result and limit channels of the frame validator,
// predicts one status per frame and compares it with what comes out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfv_frame_checker
  import lfv_pkg::*;
  import lfv_tb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_last_byte,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [2:0]           out_status,
  input  logic [31:0]          out_packet_kind,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_max_frame_size,
  output int unsigned          fail_count,
  output int unsigned          pending_count
);

  localparam int unsigned KIND_AT = 4;
  localparam int unsigned LEN_AT  = 8;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    status_t     status;
    logic [31:0] kind;
  } frame_result_t;

  frame_result_t    expected_results[$];
  logic [CNT_W-1:0] seen_bytes;
  logic [31:0]      crc_acc;
  logic [31:0]      kind_acc;
  logic [31:0]      decl_len;
  logic [31:0]      tail_crc;
  logic             magic_ok;
  logic [15:0]      last_two;
  logic [CFG_W-1:0] size_limit;
  int unsigned      mismatches = 0;

  task automatic clear_frame();
    seen_bytes = '0;
    crc_acc    = CRC_INIT;
    magic_ok   = 1'b1;
    kind_acc   = '0;
    decl_len   = '0;
    tail_crc   = '0;
    last_two   = '0;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic last);
    longint unsigned pos;
    longint unsigned dl;
    frame_result_t   res;
    pos = seen_bytes;
    dl  = decl_len;
    if (pos < KIND_AT) begin
      if (b != MAGIC_BYTES[pos[1:0]]) magic_ok = 1'b0;
    end else if (pos < LEN_AT) begin
      kind_acc |= {24'h0, b} << (8 * (pos - KIND_AT));
    end else if (pos < HEADER_BYTES) begin
      decl_len |= {24'h0, b} << (8 * (pos - LEN_AT));
    end else if (pos <= MAX_BYTES) begin
      // Payload and CRC word positions follow the declared length.
      if (pos + TAIL_BYTES < dl) begin
        crc_acc = crc32_shift_byte(crc_acc, b);
      end else if (pos + TAIL_BYTES < dl + 4) begin
        tail_crc |= {24'h0, b} << (8 * (pos + TAIL_BYTES - dl));
      end
    end
    last_two = {last_two[7:0], b};
    if (seen_bytes <= MAX_BYTES) seen_bytes++;
    if (last) begin
      res.kind = kind_acc;
      if (seen_bytes < MIN_FRAME) res.status = ST_TRUNCATED;
      else if (!magic_ok) res.status = ST_BAD_HDR;
      else if (seen_bytes > MAX_BYTES || decl_len != 32'(seen_bytes) ||
               decl_len > 32'(size_limit)) res.status = ST_BAD_SIZE;
      else if (last_two != TAIL_MARK) res.status = ST_BAD_TAIL;
      else if ((crc_acc ^ CRC_INIT) != tail_crc) res.status = ST_BAD_CRC;
      else res.status = ST_OK;
      expected_results.insert(expected_results.size(), res);
      clear_frame();
    end
  endtask

  task automatic check_result();
    frame_result_t want;
    if (expected_results.size() == 0) begin
      if (mismatches < REPORT_LIMIT)
        $display("%0t: unexpected result status %0d kind %h",
                 $realtime, out_status, out_packet_kind);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (out_status !== want.status || out_packet_kind !== want.kind) begin
        if (mismatches < REPORT_LIMIT)
          $display("%0t: result mismatch status exp %0d got %0d, kind exp %h got %h",
                   $realtime, want.status, out_status, want.kind, out_packet_kind);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_frame();
      size_limit = CFG_MAX_RESET;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_valid && cfg_ready) size_limit = cfg_max_frame_size;
      if (in_valid && in_ready) absorb_byte(in_data_byte, in_last_byte);
    end
    fail_count    <= mismatches;
    pending_count <= expected_results.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the lidar frame validator: directed frames for
// every status and the size limit boundary, then random frames under varying
// limits and back-pressure, checked transaction by transaction by
// lfv_frame_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lfv_pkg::*;
  import lfv_tb_pkg::*;

  // How a generated frame is damaged before it is sent.
  typedef enum int {
    FAULT_NONE,
    FAULT_MAGIC,
    FAULT_LENGTH,
    FAULT_TAIL,
    FAULT_CRC,
    FAULT_TRUNC,
    FAULT_NOISE
  } frame_fault_t;

  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned LEN_BYTE0        = 8;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_data_byte;
  logic             in_last_byte;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [2:0]       out_status;
  logic [31:0]      out_packet_kind;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_max_frame_size;

  int unsigned mismatch_total;
  int unsigned results_pending;

  // Idle rates in percent. The sender's rate belongs to the stimulus
  // process; the receiver's is handed to the ready process below.
  int unsigned snd_idle = 0;
  int unsigned rcv_idle = 0;

  // One long receiver stall, requested by the stimulus and timed by the
  // ready process on its own.
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;

  logic [7:0]  frame_q[$];
  int unsigned phase_bytes;

  always #1 clk = ~clk;

  lidar_frame_validator_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_packet_kind    (out_packet_kind),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_frame_size (cfg_max_frame_size)
  );

  lfv_frame_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_packet_kind    (out_packet_kind),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_frame_size (cfg_max_frame_size),
    .fail_count         (mismatch_total),
    .pending_count      (results_pending)
  );

  // Result-side back-pressure. The long stall holds ready low long enough
  // that the internal queue fills and in_ready drops.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Present one byte and hold it until the transaction completes. Valid is
  // left high afterwards so that back-to-back bytes need no gap; whoever
  // stops sending lowers it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (snd_idle != 0 && $urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    phase_bytes++;
  endtask

  // Wait until every predicted result has been seen, then let the back end
  // settle. The first edge lets the checker count the last byte's frame.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_valid          <= 1'b1;
    cfg_max_frame_size <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_length(input logic [31:0] len);
    for (int i = 0; i < 4; i++) frame_q[LEN_BYTE0 + i] = len[8*i +: 8];
  endtask

  task automatic cut_frame(input int unsigned keep);
    while (frame_q.size() > keep) void'(frame_q.pop_back());
  endtask

  task automatic add_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endtask

  // A well-formed frame: magic, type word, true length, payload, CRC word,
  // six filler bytes and the 00 FF end mark.
  task automatic build_frame(input int unsigned plen, input logic [31:0] kind);
    logic [31:0] crc;
    frame_q.delete();
    for (int i = 0; i < 4; i++) add_byte(MAGIC_BYTES[i]);
    for (int i = 0; i < 4; i++) add_byte(kind[8*i +: 8]);
    for (int i = 0; i < 4; i++) add_byte(8'h00);
    set_length(MIN_FRAME + plen);
    crc = CRC_INIT;
    repeat (plen) begin
      add_byte(8'($urandom));
      crc = crc32_shift_byte(crc, frame_q[$]);
    end
    crc ^= CRC_INIT;
    for (int i = 0; i < 4; i++) add_byte(crc[8*i +: 8]);
    repeat (6) add_byte(8'($urandom));
    add_byte(TAIL_MARK[15:8]);
    add_byte(TAIL_MARK[7:0]);
  endtask

  task automatic damage_frame(input frame_fault_t fault, input int unsigned plen);
    logic [31:0] len;
    case (fault)
      FAULT_MAGIC: begin
        frame_q[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
      end
      FAULT_LENGTH: begin
        len = MIN_FRAME + plen;
        case ($urandom_range(2))
          0:       len = $urandom_range(1) ? len + 1 : len - 1;
          1:       len = $urandom;
          default: len = $urandom_range(0, 60);
        endcase
        if (len == MIN_FRAME + plen) len++;
        set_length(len);
      end
      FAULT_TAIL: begin
        frame_q[frame_q.size() - 1 - $urandom_range(1)] ^= 8'($urandom_range(1, 255));
      end
      FAULT_CRC: begin
        // Hit either a payload byte or the stored CRC word.
        if (plen != 0 && $urandom_range(1))
          frame_q[HEADER_BYTES + $urandom_range(plen - 1)] ^= 8'($urandom_range(1, 255));
        else
          frame_q[HEADER_BYTES + plen + $urandom_range(3)] ^= 8'($urandom_range(1, 255));
      end
      FAULT_TRUNC: begin
        cut_frame($urandom_range(1, MIN_FRAME - 1));
      end
      FAULT_NOISE: begin
        foreach (frame_q[i]) if ($urandom_range(3) == 0) frame_q[i] = 8'($urandom);
        cut_frame($urandom_range(1, frame_q.size()));
      end
      default: ;
    endcase
  endtask

  task automatic emit_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic random_frame();
    int unsigned  plen;
    logic [31:0]  kind;
    frame_fault_t fault;
    int unsigned  pick;
    plen = ($urandom_range(9) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
    case ($urandom_range(9))
      0:       kind = '0;
      1:       kind = '1;
      default: kind = $urandom;
    endcase
    // Well-formed frames are the most common pick, so the checks past the header are reached.
    pick = $urandom_range(99);
    if (pick < 45)      fault = FAULT_NONE;
    else if (pick < 55) fault = FAULT_CRC;
    else if (pick < 63) fault = FAULT_LENGTH;
    else if (pick < 70) fault = FAULT_TAIL;
    else if (pick < 77) fault = FAULT_MAGIC;
    else if (pick < 85) fault = FAULT_TRUNC;
    else                fault = FAULT_NOISE;
    build_frame(plen, kind);
    damage_frame(fault, plen);
    emit_frame();
  endtask

  task automatic random_phase(input int unsigned target, input int unsigned s_idle,
                              input int unsigned r_idle, input logic [CFG_W-1:0] limit,
                              input logic long_stall);
    write_limit(limit);
    snd_idle    = s_idle;
    rcv_idle   <= r_idle;
    phase_bytes = 0;
    while (phase_bytes < target) begin
      if (long_stall && phase_bytes > target / 3) hold_req <= 1'b1;
      random_frame();
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_data_byte       <= '0;
    in_last_byte       <= 1'b0;
    cfg_valid          <= 1'b0;
    cfg_max_frame_size <= CFG_MAX_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    write_limit(CFG_MAX_RESET);

    // Directed frames: one for each status, and several status priority pairs.
    build_frame(0, 32'hFFFF_FFFF);              // shortest good frame
    emit_frame();
    build_frame(5, 32'h0000_0000);              // good, zero type word
    emit_frame();
    build_frame(0, 32'h1234_5678);              // single byte with last flag
    cut_frame(1);
    emit_frame();
    build_frame(0, 32'h89AB_CDEF);              // one byte short of minimum
    cut_frame(MIN_FRAME - 1);
    emit_frame();
    build_frame(3, $urandom);                   // last magic byte wrong
    frame_q[3] ^= 8'h80;
    emit_frame();
    build_frame(3, $urandom);                   // truncation outranks bad magic
    frame_q[1] = 8'h00;
    cut_frame(10);
    emit_frame();
    build_frame(3, $urandom);                   // bad magic outranks bad length
    frame_q[0] = 8'hFF;
    set_length(7);
    emit_frame();
    build_frame(4, $urandom);                   // declared one longer than actual
    set_length(MIN_FRAME + 5);
    emit_frame();
    build_frame(4, $urandom);                   // huge declared length
    set_length(32'hFFFF_FFFF);
    emit_frame();
    build_frame(2, $urandom);                   // end mark low byte wrong
    frame_q[$] = 8'hFE;
    emit_frame();
    build_frame(2, $urandom);                   // bad tail outranks bad CRC
    frame_q[$ - 1] = 8'h01;
    frame_q[HEADER_BYTES] ^= 8'h01;
    emit_frame();
    build_frame(6, $urandom);                   // payload byte or stored CRC word corrupted
    damage_frame(FAULT_CRC, 6);
    emit_frame();

    // Declared length against the limit, right at the boundary.
    write_limit(CFG_W'(40));
    build_frame(40 - MIN_FRAME, $urandom);
    emit_frame();
    build_frame(41 - MIN_FRAME, $urandom);
    emit_frame();
    write_limit(CFG_MAX_RESET);

    // Random part: sender light and receiver heavy, then the reverse, then
    // no idling at all, once with the long receiver stall.
    random_phase(400, 7, 80, CFG_W'($urandom_range(24, 4096)), 1'b0);
    random_phase(400, 80, 7, CFG_W'(MIN_FRAME), 1'b0);
    random_phase(400, 0, 0, CFG_MAX_RESET, 1'b1);
    random_phase(350, 0, 0, CFG_W'($urandom_range(24, 300)), 1'b0);

    wait_idle();
    if (mismatch_total == 0 && results_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
